/* rtl/spq_pkg.sv */
package spq_pkg;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [31:0] data;
    logic [7:0]         prio;
  } entry_t;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] item_data;
    logic [7:0]         item_priority;
  } in_t;

  typedef struct packed {
    logic signed [31:0] popped_data;
    logic signed [31:0] head_data;
    logic [7:0]         head_priority;
    logic               not_empty;
    logic [4:0]         occupancy;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ctl_t;

endpackage

/* rtl/sorted_priority_queue.sv */
// Sorted priority queue of DEPTH entries held in a row of cells, the lowest priority value at
// the head and equal priorities served first in, first out. One command word (push or pop) is
// taken in every clock cycle, busy never rises, and its result word appears with out_strobe
// in the cycle after acceptance, from the single register stage behind the cell row.
// The receiver cannot stall and must take every result word in the cycle it is shown.
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::in_t  in_word,
  output logic          out_strobe,
  output spq_pkg::out_t out_word
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_strobe_r;
  spq_pkg::out_t    out_r, out_nxt;
  spq_pkg::ctl_t    ctl;
  spq_pkg::entry_t  new_entry;
  spq_pkg::entry_t  cell_q   [DEPTH];
  spq_pkg::entry_t  cell_nxt [DEPTH];
  logic [DEPTH-1:0] move;
  logic [DEPTH-1:0] occ;
  logic             accept, is_full, is_empty;
  logic [CNT_W+4:0] count_wide;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign is_full   = (count_r == CNT_W'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign new_entry = '{data: in_word.item_data, prio: in_word.item_priority};

  assign ctl.push = accept && (in_word.cmd == spq_pkg::CMD_PUSH) && !is_full;
  assign ctl.pop  = accept && (in_word.cmd == spq_pkg::CMD_POP) && !is_empty;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      spq_pkg::entry_t left_e, right_e;
      logic            left_m;

      assign occ[gi] = (CNT_W'(gi) < count_r);

      if (gi == 0) begin : g_first
        assign left_e = new_entry;
        assign left_m = 1'b0;
      end else begin : g_mid
        assign left_e = cell_q[gi-1];
        assign left_m = move[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign right_e = cell_q[gi];
      end else begin : g_inner
        assign right_e = cell_q[gi+1];
      end

      spq_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .new_entry   (new_entry),
        .left_entry  (left_e),
        .right_entry (right_e),
        .left_move   (left_m),
        .occ         (occ[gi]),
        .move        (move[gi]),
        .entry       (cell_q[gi]),
        .entry_nxt   (cell_nxt[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign count_wide = {5'b0, count_nxt};

  always_comb begin
    out_nxt               = '0;
    out_nxt.occupancy     = count_wide[4:0];
    out_nxt.not_empty     = (count_nxt != '0);
    out_nxt.status        = spq_pkg::ST_OK;
    if (ctl.pop) begin
      out_nxt.popped_data = cell_q[0].data;
    end
    if (count_nxt != '0) begin
      out_nxt.head_data     = cell_nxt[0].data;
      out_nxt.head_priority = cell_nxt[0].prio;
    end
    if ((in_word.cmd == spq_pkg::CMD_PUSH) && is_full) begin
      out_nxt.status = spq_pkg::ST_FULL;
    end else if ((in_word.cmd == spq_pkg::CMD_POP) && is_empty) begin
      out_nxt.status = spq_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_r;

endmodule

/* rtl/spq_cell.sv */
module spq_cell (
  input  logic            clk,
  input  spq_pkg::ctl_t   ctl,
  input  spq_pkg::entry_t new_entry,
  input  spq_pkg::entry_t left_entry,
  input  spq_pkg::entry_t right_entry,
  input  logic            left_move,
  input  logic            occ,
  output logic            move,
  output spq_pkg::entry_t entry,
  output spq_pkg::entry_t entry_nxt
);

  spq_pkg::entry_t entry_r;

  // A cell moves on a push unless it holds an entry that ranks no later than the new one.
  assign move = !(occ && (entry_r.prio <= new_entry.prio));

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.push && move) begin
      entry_nxt = left_move ? left_entry : new_entry;
    end else if (ctl.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

/* rtl/spq_checker.sv */
module spq_checker #(
  parameter int DEPTH = 16
) (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input spq_pkg::out_t out_word,
  input logic          out_strobe
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W+4:0] DEPTH_WIDE = (CNT_W + 5)'(DEPTH);

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(start && !busy) |-> out_strobe)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy))
    else $error("result word without an accepted command");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_word.not_empty |->
      out_word.head_data == 0 && out_word.head_priority == 8'd0 && out_word.occupancy == 5'd0)
    else $error("empty queue reports a head");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.status == spq_pkg::ST_FULL |->
      out_word.occupancy == DEPTH_WIDE[4:0] && out_word.popped_data == 0)
    else $error("dropped push with queue not full");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_word   (out_word),
  .out_strobe (out_strobe)
);

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH        = 16;
  localparam int TOTAL_WORDS  = 950;
  localparam int CALM_TAIL    = 60;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  logic          clk   = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  spq_pkg::in_t  in_word = '0;
  logic          out_strobe;
  spq_pkg::out_t out_word;

  spq_pkg::in_t    pending_words[$];
  spq_pkg::out_t   expected_reports[$];
  spq_pkg::entry_t held_entries[$];
  int              gap_left    = 0;
  int              error_count = 0;
  int              cycle_count = 0;

  sorted_priority_queue #(
    .DEPTH(DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one command to the shadow queue and returns the report the block should give.
  function automatic spq_pkg::out_t serve_command(spq_pkg::in_t w);
    spq_pkg::out_t   r;
    spq_pkg::entry_t e;
    int              pos;
    r = '0;
    r.status = spq_pkg::ST_OK;
    if (w.cmd == spq_pkg::CMD_PUSH) begin
      if (held_entries.size() >= DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_entries.size() && held_entries[pos].prio <= w.item_priority) begin
          pos++;
        end
        e.data = w.item_data;
        e.prio = w.item_priority;
        held_entries.insert(pos, e);
      end
    end else if (held_entries.size() == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.popped_data = held_entries[0].data;
      held_entries.delete(0);
    end
    if (held_entries.size() > 0) begin
      r.head_data     = held_entries[0].data;
      r.head_priority = held_entries[0].prio;
      r.not_empty     = 1'b1;
    end
    r.occupancy = 5'(held_entries.size());
    return r;
  endfunction

  task automatic queue_word(logic cmd, logic signed [31:0] data, logic [7:0] prio);
    spq_pkg::in_t w;
    w.cmd           = cmd;
    w.item_data     = data;
    w.item_priority = prio;
    pending_words.push_back(w);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      in_word  <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        expected_reports.push_back(serve_command(in_word));
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (pending_words.size() == 0) begin
          start <= 1'b0;
        end else if (pending_words.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
          gap_left <= $urandom_range(1, 19) - 1;
          start    <= 1'b0;
        end else begin
          in_word <= pending_words.pop_front();
          start   <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    spq_pkg::out_t want;
    int            bad;
    bad = 0;
    if (rst_n && out_strobe) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result word");
        bad++;
      end else begin
        want = expected_reports.pop_front();
        if (out_word.popped_data !== want.popped_data) begin
          $error("popped_data: expected %0d, got %0d", want.popped_data, out_word.popped_data);
          bad++;
        end
        if (out_word.head_data !== want.head_data) begin
          $error("head_data: expected %0d, got %0d", want.head_data, out_word.head_data);
          bad++;
        end
        if (out_word.head_priority !== want.head_priority) begin
          $error("head_priority: expected %0d, got %0d", want.head_priority,
                 out_word.head_priority);
          bad++;
        end
        if (out_word.not_empty !== want.not_empty) begin
          $error("not_empty: expected %0d, got %0d", want.not_empty, out_word.not_empty);
          bad++;
        end
        if (out_word.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, out_word.occupancy);
          bad++;
        end
        if (out_word.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word.status);
          bad++;
        end
      end
    end
    if (bad != 0) begin
      error_count <= error_count + bad;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int run_len;
    int mode;
    int push_pct;
    int narrow;
    int k;
    logic cmd;
    logic [7:0] prio;

    // Directed opening: empty pop, extreme fields, ties, filling to the brim and overflow.
    queue_word(spq_pkg::CMD_POP, 32'sd0, 8'd0);
    queue_word(spq_pkg::CMD_PUSH, 32'h8000_0000, 8'd0);
    queue_word(spq_pkg::CMD_PUSH, 32'h7FFF_FFFF, 8'd255);
    queue_word(spq_pkg::CMD_PUSH, -32'sd1, 8'd255);
    queue_word(spq_pkg::CMD_PUSH, 32'sd0, 8'd128);
    queue_word(spq_pkg::CMD_PUSH, 32'sd5, 8'd0);
    for (k = 0; k < 10; k++) begin
      queue_word(spq_pkg::CMD_PUSH, 32'sd100 + k, 8'(k * 23));
    end
    queue_word(spq_pkg::CMD_PUSH, 32'h5555_5555, 8'hAA);
    queue_word(spq_pkg::CMD_PUSH, 32'h2AAA_AAAA, 8'h55);
    for (k = 0; k < 5; k++) begin
      queue_word(spq_pkg::CMD_POP, $urandom, 8'($urandom));
    end

    while (pending_words.size() < TOTAL_WORDS) begin
      run_len = $urandom_range(10, 40);
      mode    = $urandom_range(MODE_FILL, MODE_MIXED);
      narrow  = $urandom_range(0, 1);
      case (mode)
        MODE_FILL:  push_pct = 85;
        MODE_DRAIN: push_pct = 15;
        default:    push_pct = 50;
      endcase
      for (k = 0; k < run_len; k++) begin
        cmd = ($urandom_range(0, 99) < push_pct) ? spq_pkg::CMD_PUSH : spq_pkg::CMD_POP;
        if (narrow != 0) begin
          prio = 8'($urandom_range(0, 3));
        end else begin
          prio = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 15) == 0) begin
          prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        queue_word(cmd, $urandom, prio);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || start) begin
      @(posedge clk);
    end
    while (expected_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
